// File: rtl/hss_pkg.sv
// hss_pkg: shared types and constants for the hue-saturation segment scorer
// used by hss_ctrl, hss_dp and the top level hue_sat_segment_histogram_scorer
`default_nettype none
package hss_pkg;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TAU = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN = 2'd2;
	localparam logic [15:0] TAU_RESET = 16'd45875;
	localparam logic [7:0] SAT_MIN_RESET = 8'd25;
	localparam logic [7:0] VAL_MIN_RESET = 8'd50;
	localparam logic [16:0] Q_ONE = 17'h10000;

	// commands from controller to datapath
	typedef struct packed {
		logic take;      // capture input word
		logic load;      // write model bin
		logic count;     // count captured pixel
		logic clr_all;   // clear count and hist valid bits
		logic walk_start;// restart bin walk
		logic walk_step; // issue next bin read
		logic sel_bg;    // walk against background model
		logic acc_clr;   // clear accumulator
		logic sq_start;  // start square root
		logic acc_add;   // add root to accumulator
		logic clr_step;  // advance walk address, no read
		logic out_load;  // load result register
	} hss_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_load;
		logic cand;
		logic rend;
		logic walk_last;
		logic div_done;
		logic sq_done;
		logic above_tau;
		logic out_full;
	} hss_sts_t;
endpackage
`default_nettype wire

// File: rtl/hss_dp.sv
// hss_dp: datapath with histogram and model memories, serial divider, serial square root
// depends on hss_pkg
`default_nettype none
module hss_dp #(
	parameter int unsigned HIST_BINS = 8,
	parameter int unsigned ROW_LEN = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire hss_pkg::hss_cmd_t cmd,
	output hss_pkg::hss_sts_t sts,
	input  wire logic cfg_we,
	input  wire logic [hss_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [63:0] in_data,
	input  wire logic [1:0] in_user,
	input  wire logic in_last,
	output logic [15:0] out_score,
	output logic [1:0] out_user,
	output logic out_last,
	output logic out_valid,
	input  wire logic out_ready
);
	localparam int unsigned NB = HIST_BINS * HIST_BINS;
	localparam int unsigned AW = (NB > 1) ? $clog2(NB) : 1;
	localparam int unsigned CW = $clog2(ROW_LEN + 1);
	localparam int unsigned BW = $clog2(HIST_BINS);
	// product w*h<<16 width
	localparam int unsigned PW = 16 + CW + 16;
	localparam int unsigned RW = (PW + 1) / 2;
	localparam int unsigned ACCW = RW + AW + 1;

	// configuration registers
	logic [15:0] tau_q;
	logic [7:0] sat_min_q, val_min_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= hss_pkg::TAU_RESET;
			sat_min_q <= hss_pkg::SAT_MIN_RESET;
			val_min_q <= hss_pkg::VAL_MIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hss_pkg::REG_TAU: tau_q <= cfg_data;
				hss_pkg::REG_SAT_MIN: sat_min_q <= cfg_data[7:0];
				hss_pkg::REG_VAL_MIN: val_min_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured input word
	logic is_load_q, cand_q, rend_q;
	logic [7:0] hue_q, sat_q, val_q;
	logic [5:0] bidx_q;
	logic [15:0] fgw_q, bgw_q;
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			is_load_q <= in_user[0];
			cand_q <= in_user[1];
			rend_q <= in_last;
			hue_q <= in_data[7:0];
			sat_q <= in_data[15:8];
			val_q <= in_data[23:16];
			bidx_q <= in_data[29:24];
			fgw_q <= in_data[45:30];
			bgw_q <= in_data[61:46];
		end
	end

	// bin of captured pixel
	logic [AW-1:0] pix_bin;
	logic counts;
	logic [BW-1:0] hb, sb;
	always_comb begin
		hb = BW'((16'(hue_q) * 16'(HIST_BINS)) >> 8);
		sb = BW'((16'(sat_q) * 16'(HIST_BINS)) >> 8);
		pix_bin = AW'(hb * HIST_BINS + sb);
		counts = (sat_q > sat_min_q) && (val_q > val_min_q);
	end

	// walk address
	logic [AW-1:0] wa_q;
	logic wv_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= '0;
			wv_s1 <= 1'b0;
		end else begin
			wv_s1 <= cmd.walk_step;
			if (cmd.walk_start) wa_q <= '0;
			else if (cmd.walk_step || cmd.clr_step) wa_q <= wa_q + AW'(1);
		end
	end
	assign sts.walk_last = (wa_q == AW'(NB - 1));

	// model memories
	logic [15:0] fg_mem [NB];
	logic [15:0] bg_mem [NB];
	logic [15:0] w_s1;
	always_ff @(posedge clk) begin
		if (cmd.load && (32'(bidx_q) < NB)) begin
			fg_mem[AW'(bidx_q)] <= fgw_q;
			bg_mem[AW'(bidx_q)] <= bgw_q;
		end
		w_s1 <= cmd.sel_bg ? bg_mem[wa_q] : fg_mem[wa_q];
	end

	// histogram memory with one valid bit per bin, one read port
	// outside a walk the pixel bin is read a cycle ahead of the count
	logic [CW-1:0] hist_mem [NB];
	logic [NB-1:0] hv_q;
	logic [CW-1:0] h_s1;
	logic [CW-1:0] hrd;
	logic [AW-1:0] hra;
	assign hra = cmd.walk_step ? wa_q : pix_bin;
	always_ff @(posedge clk) begin
		hrd <= hist_mem[hra];
		if (cmd.count && counts) begin
			if (!hv_q[pix_bin]) hist_mem[pix_bin] <= CW'(1);
			else if (hrd < CW'(ROW_LEN))
				hist_mem[pix_bin] <= hrd + CW'(1);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hv_q <= '0;
		else if (cmd.clr_all) hv_q <= '0;
		else if (cmd.count && counts) hv_q[pix_bin] <= 1'b1;
	end
	logic hv_s1;
	always_ff @(posedge clk) hv_s1 <= hv_q[wa_q];
	assign h_s1 = hv_s1 ? hrd : '0;

	// segment count
	logic [CW-1:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.clr_all) cnt_q <= '0;
		else if (cmd.count && counts && cnt_q < CW'(ROW_LEN)) cnt_q <= cnt_q + CW'(1);
	end

	// product stage
	logic [PW-1:0] p_s2;
	logic p_v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) p_v_s2 <= 1'b0;
		else p_v_s2 <= wv_s1;
	end
	always_ff @(posedge clk) p_s2 <= (PW'(w_s1) * PW'(h_s1)) << 16;

	// restoring divider by n, one bit a cycle
	logic [PW-1:0] dq_q;
	logic [CW:0] drem_q;
	logic [$clog2(PW+1)-1:0] dcnt_q;
	logic dbusy_q, ddone_q;
	logic [CW-1:0] n_q;
	logic [CW:0] dtry;
	always_comb dtry = {drem_q[CW-1:0], dq_q[PW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (p_v_s2) begin
				dbusy_q <= 1'b1;
				dcnt_q <= ($clog2(PW+1))'(PW);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == ($clog2(PW+1))'(1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		n_q <= (cnt_q == '0) ? CW'(1) : cnt_q;
		if (p_v_s2) begin
			dq_q <= p_s2;
			drem_q <= '0;
		end else if (dbusy_q) begin
			if (dtry >= {1'b0, n_q}) begin
				drem_q <= dtry - {1'b0, n_q};
				dq_q <= {dq_q[PW-2:0], 1'b1};
			end else begin
				drem_q <= dtry;
				dq_q <= {dq_q[PW-2:0], 1'b0};
			end
		end
	end
	assign sts.div_done = ddone_q;

	// digit-by-digit square root, one result bit a cycle
	logic [2*RW-1:0] sx_q;
	logic [RW+1:0] srem_q;
	logic [RW-1:0] sr_q;
	logic [$clog2(RW+1)-1:0] scnt_q;
	logic sbusy_q, sdone_q;
	logic [RW+1:0] strial, snext;
	always_comb begin
		snext = {srem_q[RW-1:0], sx_q[2*RW-1 -: 2]};
		strial = snext - {sr_q, 2'b01};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
			scnt_q <= '0;
		end else begin
			sdone_q <= 1'b0;
			if (cmd.sq_start) begin
				sbusy_q <= 1'b1;
				scnt_q <= ($clog2(RW+1))'(RW);
			end else if (sbusy_q) begin
				scnt_q <= scnt_q - 1'b1;
				if (scnt_q == ($clog2(RW+1))'(1)) begin
					sbusy_q <= 1'b0;
					sdone_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.sq_start) begin
			sx_q <= (2*RW)'(dq_q);
			srem_q <= '0;
			sr_q <= '0;
		end else if (sbusy_q) begin
			sx_q <= sx_q << 2;
			if (!strial[RW+1]) begin
				srem_q <= strial;
				sr_q <= {sr_q[RW-2:0], 1'b1};
			end else begin
				srem_q <= snext;
				sr_q <= {sr_q[RW-2:0], 1'b0};
			end
		end
	end
	assign sts.sq_done = sdone_q;

	// coefficient accumulator
	logic [ACCW-1:0] acc_q;
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + ACCW'(sr_q);
	end
	assign sts.above_tau = acc_q > ACCW'(tau_q);

	// result register, one minus a zero coefficient saturates to full scale
	logic ov_q;
	logic [15:0] score_q;
	logic cand_out_q, rend_out_q;
	logic [15:0] sc;
	always_comb begin
		if (!cand_q) sc = '0;
		else if (cmd.sel_bg) sc = (acc_q >= ACCW'(hss_pkg::Q_ONE)) ? 16'd0
			: (acc_q == '0) ? 16'hFFFF
			: 16'(ACCW'(hss_pkg::Q_ONE) - acc_q);
		else sc = (acc_q > ACCW'(16'hFFFF)) ? 16'hFFFF : acc_q[15:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.out_load) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			score_q <= sc;
			cand_out_q <= cand_q;
			rend_out_q <= rend_q;
		end
	end
	assign out_valid = ov_q;
	assign out_score = score_q;
	assign out_user = {1'b0, cand_out_q};
	assign out_last = rend_out_q;

	assign sts.is_load = is_load_q;
	assign sts.cand = cand_q;
	assign sts.rend = rend_q;
	assign sts.out_full = ov_q && !out_ready;
endmodule
`default_nettype wire

// File: rtl/hss_ctrl.sv
// hss_ctrl: sequencer for load, count, coefficient walks and histogram clear
// depends on hss_pkg
`default_nettype none
module hss_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire hss_pkg::hss_sts_t sts,
	output hss_pkg::hss_cmd_t cmd
);
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DEC    = 10'b0000000010,
		ST_ISSUE  = 10'b0000000100,
		ST_DIV    = 10'b0000001000,
		ST_SQRT   = 10'b0000010000,
		ST_CHECK  = 10'b0000100000,
		ST_CLEAR  = 10'b0001000000,
		ST_COUNT  = 10'b0010000000,
		ST_OUT    = 10'b0100000000,
		ST_ENDROW = 10'b1000000000
	} state_t;

	state_t st_q, st_d;
	logic bg_q, bg_d, last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			bg_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			st_q <= st_d;
			bg_q <= bg_d;
			last_q <= last_d;
		end
	end

	// next state and commands
	always_comb begin
		st_d = st_q;
		bg_d = bg_q;
		last_d = last_q;
		cmd = '0;
		cmd.sel_bg = bg_q;
		in_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					st_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (sts.is_load) begin
					cmd.load = 1'b1;
					st_d = ST_IDLE;
				end else if (sts.cand) begin
					bg_d = 1'b0;
					cmd.sel_bg = 1'b0;
					cmd.acc_clr = 1'b1;
					cmd.walk_start = 1'b1;
					st_d = ST_ISSUE;
				end else st_d = ST_COUNT;
			end
			ST_ISSUE: begin
				last_d = sts.walk_last;
				cmd.walk_step = 1'b1;
				st_d = ST_DIV;
			end
			ST_DIV: if (sts.div_done) begin
				cmd.sq_start = 1'b1;
				st_d = ST_SQRT;
			end
			ST_SQRT: if (sts.sq_done) begin
				cmd.acc_add = 1'b1;
				st_d = last_q ? ST_CHECK : ST_ISSUE;
			end
			ST_CHECK: begin
				if (!bg_q && sts.above_tau) begin
					bg_d = 1'b1;
					cmd.acc_clr = 1'b1;
					cmd.walk_start = 1'b1;
					st_d = ST_ISSUE;
				end else if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					cmd.clr_all = 1'b1;
					cmd.walk_start = 1'b1;
					st_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				st_d = sts.cand ? ST_IDLE : ST_OUT;
				if (sts.rend) st_d = ST_ENDROW;
				else if (sts.cand) st_d = ST_IDLE;
			end
			ST_OUT: if (!sts.out_full) begin
				cmd.out_load = 1'b1;
				st_d = ST_IDLE;
			end
			ST_ENDROW: if (sts.cand || !sts.out_full) begin
				cmd.out_load = !sts.cand;
				cmd.clr_all = 1'b1;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/hue_sat_segment_histogram_scorer.sv
// hue_sat_segment_histogram_scorer: top level, controller and datapath joined
// depends on hss_pkg, hss_ctrl, hss_dp
//
// A new word is taken only once the last one is done. A candidate pixel walks all bins
// against the foreground model, and again against the background model when above tau;
// each bin is read, multiplied in the product stage, then goes through a bit-serial
// divider and a bit-serial square root before the next bin is read. A result waiting in
// the output register holds off the next word. The histogram clears at once through
// per-bin valid bits.
`default_nettype none
module hue_sat_segment_histogram_scorer #(
	parameter int unsigned HIST_BINS = 8,
	parameter int unsigned ROW_LEN = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [hss_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// hue, sat, val, bin_index, fg_weight, bg_weight, zero fill
	input  wire logic [63:0] s_axis_tdata,
	// req_type, is_candidate
	input  wire logic [1:0] s_axis_tuser,
	input  wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// score
	output logic [15:0] m_axis_tdata,
	// was_candidate
	output logic m_axis_tuser,
	output logic m_axis_tlast
);
	hss_pkg::hss_cmd_t cmd;
	hss_pkg::hss_sts_t sts;
	logic [1:0] ou;

	hss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .sts(sts), .cmd(cmd)
	);

	hss_dp #(.HIST_BINS(HIST_BINS), .ROW_LEN(ROW_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_data(s_axis_tdata), .in_user(s_axis_tuser), .in_last(s_axis_tlast),
		.out_score(m_axis_tdata), .out_user(ou), .out_last(m_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
	);
	assign m_axis_tuser = ou[0] | (ou[1] & 1'b0);
endmodule
`default_nettype wire
